/* hw/rtl/itf_pkg.sv */
// itf_pkg: shared constants, register codes and helpers for the IMU tilt filter.
// Used by itf_cordic and imu_tilt_filter; no dependencies.
package itf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int STEP_IDX_W       = 5;
  localparam int ANGLE_W          = 16;
  localparam int COEFF_W          = 16;
  localparam int Z_W              = 34;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_OFFSET  = 2'd1;

  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd62259;

  // pi/180/131 scaled to Q4.12 output, in Q0.20
  localparam logic signed [20:0] RATE_GAIN = 21'sd572224;

  // atan(2^-i) in Q2.30, rounded
  function automatic logic [31:0] atan_q30(input logic [STEP_IDX_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd843314857;
      5'd1:  r = 32'd497837829;
      5'd2:  r = 32'd263043837;
      5'd3:  r = 32'd133525159;
      5'd4:  r = 32'd67021686;
      5'd5:  r = 32'd33543516;
      5'd6:  r = 32'd16775851;
      5'd7:  r = 32'd8388437;
      5'd8:  r = 32'd4194283;
      5'd9:  r = 32'd2097149;
      5'd10: r = 32'd1048576;
      5'd11: r = 32'd524288;
      5'd12: r = 32'd262144;
      5'd13: r = 32'd131072;
      5'd14: r = 32'd65536;
      5'd15: r = 32'd32768;
      5'd16: r = 32'd16384;
      5'd17: r = 32'd8192;
      5'd18: r = 32'd4096;
      5'd19: r = 32'd2048;
      5'd20: r = 32'd1024;
      5'd21: r = 32'd512;
      5'd22: r = 32'd256;
      5'd23: r = 32'd128;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat16(input logic signed [63:0] v);
    logic signed [ANGLE_W-1:0] r;
    if (v > 64'sd32767) r = 16'sd32767;
    else if (v < -64'sd32768) r = -16'sd32768;
    else r = v[ANGLE_W-1:0];
    return r;
  endfunction

endpackage

/* hw/rtl/imu_tilt_filter.sv */
// imu_tilt_filter: pitch/roll from one accelerometer sample, filtered roll and rate.
// Depends on itf_pkg, itf_isqrt and itf_cordic.
//
// Input channel: in_valid/in_stall with accel_x, accel_y, accel_z, gyro_y. A transfer
// happens when in_valid is high and in_stall is low. in_stall stays high from the
// transfer until the result has been moved into the output register.
// Output channel: out_valid/out_stall with pitch_angle, roll_angle, roll_smoothed,
// body_rate and rate_highpassed. A result holds while out_stall is high; the block
// takes the next sample as soon as that result sits in the output register.
// Each sample goes through seven products on one shared multiplier, then the
// bit-serial square root and the iterative CORDIC, each run twice (pitch, then roll).
// Configuration: cfg_valid/cfg_ready, always ready; index 0 is filter_coeff,
// index 1 is roll_offset, other indexes are dropped. Write only while idle.
// Reset clears the filter history, loads filter_coeff with 0.95 and roll_offset
// with zero, and empties the output register.
module imu_tilt_filter #(
  parameter int SAMPLE_WIDTH = itf_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = itf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0]      accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0]      accel_z,
  input  logic signed [SAMPLE_WIDTH-1:0]      gyro_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [itf_pkg::ANGLE_W-1:0]  pitch_angle,
  output logic signed [itf_pkg::ANGLE_W-1:0]  roll_angle,
  output logic signed [itf_pkg::ANGLE_W-1:0]  roll_smoothed,
  output logic signed [itf_pkg::ANGLE_W-1:0]  body_rate,
  output logic signed [itf_pkg::ANGLE_W-1:0]  rate_highpassed,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [itf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [itf_pkg::COEFF_W-1:0]         cfg_data
);
  localparam int SW = SAMPLE_WIDTH;
  localparam int MW = (SW > 21) ? SW : 21;
  localparam int PW = 2 * MW;
  localparam int HW = PW + 2;
  localparam int AW = itf_pkg::ANGLE_W;

  localparam logic [2:0] OP_SQ_X  = 3'd0;
  localparam logic [2:0] OP_SQ_Y  = 3'd1;
  localparam logic [2:0] OP_SQ_Z  = 3'd2;
  localparam logic [2:0] OP_LP_A  = 3'd3;
  localparam logic [2:0] OP_LP_B  = 3'd4;
  localparam logic [2:0] OP_RATE  = 3'd5;
  localparam logic [2:0] OP_HP    = 3'd6;
  localparam logic [2:0] OP_NONE  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_POST1, ST_POST2, ST_SQRT, ST_CORD, ST_DONE
  } state_t;

  state_t state;

  logic [itf_pkg::COEFF_W-1:0] coeff;
  logic signed [AW-1:0]        roll_offset;
  logic signed [AW-1:0]        last_roll;
  logic signed [AW-1:0]        lowpass_out;
  logic signed [AW-1:0]        last_rate;
  logic signed [AW-1:0]        highpass_out;

  logic signed [SW-1:0] ax, ay, az, gy;
  logic [2:0]           mul_idx;
  logic [2:0]           mul_dst;
  logic signed [PW-1:0] mul_p;
  logic [2*SW-1:0]      sq_x, sq_y, sq_z;
  logic signed [PW-1:0] p_lr, p_lp, p_rate, p_hp;
  logic signed [AW-1:0] rate_r, smooth_r, hp_r, pitch_r, roll_r;
  logic                 phase;

  logic signed [MW-1:0] op_a, op_b;
  logic signed [HW-1:0] smooth_sum, rate_sum, hp_sum;
  logic signed [AW:0]   rate_diff;
  logic signed [AW:0]   roll_diff;

  logic                 sqrt_start, sqrt_done;
  logic [2*SW-1:0]      sqrt_in;
  logic [SW-1:0]        sqrt_root;
  logic                 cordic_start, cordic_done;
  logic signed [SW:0]   cordic_num;
  logic signed [AW-1:0] cordic_angle;

  // shared multiplier operand select
  always_comb begin
    case (mul_idx)
      OP_SQ_X: begin op_a = MW'(ax); op_b = MW'(ax); end
      OP_SQ_Y: begin op_a = MW'(ay); op_b = MW'(ay); end
      OP_SQ_Z: begin op_a = MW'(az); op_b = MW'(az); end
      OP_LP_A: begin
        op_a = MW'(signed'({1'b0, 17'(17'h10000 - {1'b0, coeff})}));
        op_b = MW'(last_roll);
      end
      OP_LP_B: begin op_a = MW'(signed'({1'b0, coeff})); op_b = MW'(lowpass_out); end
      OP_RATE: begin op_a = MW'(gy); op_b = MW'(itf_pkg::RATE_GAIN); end
      OP_HP:   begin op_a = MW'(signed'({1'b0, coeff})); op_b = MW'(highpass_out); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign smooth_sum = (HW'(p_lr) + HW'(p_lp) + HW'(32768)) >>> 16;
  assign rate_sum   = (HW'(p_rate) + HW'(524288)) >>> 20;
  assign rate_diff  = (AW+1)'(rate_r) - (AW+1)'(last_rate);
  assign hp_sum     = (HW'(p_hp) + (HW'(rate_diff) <<< 16) + HW'(32768)) >>> 16;
  assign roll_diff  = (AW+1)'(cordic_angle) - (AW+1)'(roll_offset);

  assign sqrt_start   = (state == ST_POST2) || ((state == ST_CORD) && cordic_done && !phase);
  assign sqrt_in      = (phase || state == ST_CORD) ? sq_y + sq_z : sq_x + sq_z;
  assign cordic_start = (state == ST_SQRT) && sqrt_done;
  assign cordic_num   = phase ? -((SW+1)'(ax)) : (SW+1)'(ay);

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  itf_isqrt #(.SW(SW)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  itf_cordic #(.SW(SW), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .num   (cordic_num),
    .den   (sqrt_root),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      coeff        <= itf_pkg::COEFF_RESET;
      roll_offset  <= '0;
      last_roll    <= '0;
      lowpass_out  <= '0;
      last_rate    <= '0;
      highpass_out <= '0;
      mul_idx      <= OP_SQ_X;
      mul_dst      <= OP_NONE;
      phase        <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;

      if (cfg_valid) begin
        case (cfg_index)
          itf_pkg::REG_FILTER_COEFF: coeff <= cfg_data;
          itf_pkg::REG_ROLL_OFFSET:  roll_offset <= signed'(cfg_data);
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ax      <= accel_x;
            ay      <= accel_y;
            az      <= accel_z;
            gy      <= gyro_y;
            mul_idx <= OP_SQ_X;
            mul_dst <= OP_NONE;
            phase   <= 1'b0;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          mul_p   <= op_a * op_b;
          mul_dst <= mul_idx;
          mul_idx <= mul_idx + 1'b1;
          // store the product issued last cycle
          case (mul_dst)
            OP_SQ_X: sq_x   <= mul_p[2*SW-1:0];
            OP_SQ_Y: sq_y   <= mul_p[2*SW-1:0];
            OP_SQ_Z: sq_z   <= mul_p[2*SW-1:0];
            OP_LP_A: p_lr   <= mul_p;
            OP_LP_B: p_lp   <= mul_p;
            OP_RATE: p_rate <= mul_p;
            OP_HP:   p_hp   <= mul_p;
            default: ;
          endcase
          if (mul_idx == OP_NONE) state <= ST_POST1;
        end
        ST_POST1: begin
          rate_r      <= itf_pkg::sat16(64'(rate_sum));
          smooth_r    <= itf_pkg::sat16(64'(smooth_sum));
          lowpass_out <= itf_pkg::sat16(64'(smooth_sum));
          state       <= ST_POST2;
        end
        ST_POST2: begin
          hp_r         <= itf_pkg::sat16(64'(hp_sum));
          highpass_out <= itf_pkg::sat16(64'(hp_sum));
          last_rate    <= rate_r;
          state        <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sqrt_done) state <= ST_CORD;
        end
        ST_CORD: begin
          if (cordic_done) begin
            if (!phase) begin
              pitch_r <= cordic_angle;
              phase   <= 1'b1;
              state   <= ST_SQRT;
            end else begin
              roll_r <= itf_pkg::sat16(64'(roll_diff));
              state  <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            pitch_angle     <= pitch_r;
            roll_angle      <= roll_r;
            roll_smoothed   <= smooth_r;
            body_rate       <= rate_r;
            rate_highpassed <= hp_r;
            out_valid       <= 1'b1;
            last_roll       <= roll_r;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_MUL))
    else $error("accepted sample did not start the multiply phase");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result appeared outside the completion state");

  a_sqrt_in_phase: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> (state == ST_SQRT))
    else $error("square root finished outside its wait state");

  a_cordic_in_phase: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> (state == ST_CORD))
    else $error("CORDIC finished outside its wait state");

endmodule

/* hw/rtl/itf_isqrt.sv */
// itf_isqrt: iterative floor square root, one result bit per cycle.
// Depends on nothing; instantiated by imu_tilt_filter.
module itf_isqrt #(
  parameter int SW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*SW-1:0] radicand,
  output logic            done,
  output logic [SW-1:0]   root
);
  localparam int CNT_W = $clog2(SW + 1);

  logic [2*SW-1:0] val;
  logic [SW+1:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic            run;

  logic [SW+1:0] rem_sh;
  logic [SW+1:0] trial;
  logic          fits;

  assign rem_sh = {rem[SW-1:0], val[2*SW-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        val  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        val  <= {val[2*SW-3:0], 2'b00};
        rem  <= fits ? rem_sh - trial : rem_sh;
        root <= {root[SW-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(SW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/itf_cordic.sv */
// itf_cordic: iterative vectoring CORDIC, atan2(num, den) in Q3.13 radians.
// Depends on itf_pkg for the arctangent table and saturation.
module itf_cordic #(
  parameter int SW    = 16,
  parameter int STEPS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [SW:0]                    num,
  input  logic [SW-1:0]                         den,
  output logic                                  done,
  output logic signed [itf_pkg::ANGLE_W-1:0]    angle
);
  localparam int NSTEPS = (STEPS > itf_pkg::ATAN_ENTRIES) ? itf_pkg::ATAN_ENTRIES :
                          (STEPS < 1) ? 1 : STEPS;
  localparam int CW = SW + 17;

  logic signed [CW-1:0]            x;
  logic signed [CW-1:0]            y;
  logic signed [itf_pkg::Z_W-1:0]  z;
  logic [itf_pkg::STEP_IDX_W-1:0]  step;
  logic                            run;
  logic                            zero;

  logic signed [CW-1:0]           x_sh;
  logic signed [CW-1:0]           y_sh;
  logic signed [itf_pkg::Z_W-1:0] rot;
  logic signed [itf_pkg::Z_W-1:0] z_rnd;

  assign x_sh  = x >>> step;
  assign y_sh  = y >>> step;
  assign rot   = signed'({2'b00, itf_pkg::atan_q30(step)});
  assign z_rnd = (z + itf_pkg::Z_W'(65536)) >>> 17;
  assign angle = zero ? '0 : itf_pkg::sat16(64'(z_rnd));

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= CW'(signed'({1'b0, den})) <<< 14;
        y    <= CW'(num) <<< 14;
        z    <= '0;
        step <= '0;
        zero <= (num == '0) && (den == '0);
        run  <= 1'b1;
      end else if (run) begin
        // rotate toward the x axis
        if (y >= 0) begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + rot;
        end else begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - rot;
        end
        step <= step + 1'b1;
        if (step == itf_pkg::STEP_IDX_W'(NSTEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* tb/tb.sv */
// tb: self-checking regression for imu_tilt_filter (tilt angles, filtered roll and rate).
// Depends on itf_pkg and the imu_tilt_filter RTL; predicts every result in place.
`timescale 1ns / 100ps

module tb;

  localparam int CLK_PERIOD = 8;
  localparam int STEPS = itf_pkg::CORDIC_STEPS_DEF;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam logic [itf_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [itf_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] smooth;
    logic signed [15:0] rate;
    logic signed [15:0] rate_hp;
  } tilt_result_t;

  localparam longint ATAN_TAB [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021686, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0, gyro_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] pitch_angle, roll_angle, roll_smoothed, body_rate, rate_highpassed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [itf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [itf_pkg::COEFF_W-1:0] cfg_data = '0;

  // predictor state
  logic [15:0] mdl_coeff;
  logic signed [15:0] mdl_offset, mdl_last_roll, mdl_lowpass, mdl_last_rate, mdl_highpass;

  tilt_result_t expected_tilt_q [$];
  int errors = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  longint cycles = 0;
  int burst_left = 0;

  imu_tilt_filter DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .gyro_y(gyro_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .pitch_angle(pitch_angle), .roll_angle(roll_angle), .roll_smoothed(roll_smoothed),
    .body_rate(body_rate), .rate_highpassed(rate_highpassed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(r);
  endfunction

  // vectoring CORDIC, angle in Q3.13
  function automatic longint vector_angle(longint num, longint den);
    longint x, y, z, nx;
    x = den * 16384;
    y = num * 16384;
    z = 0;
    if (num == 0 && den == 0) return 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_TAB[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_TAB[i];
      end
      x = nx;
    end
    return clamp16((z + 65536) >>> 17);
  endfunction

  // advance the filter state by one sample and return the expected result
  function automatic tilt_result_t predict_tilt(longint ax, longint ay, longint az,
                                                longint gy);
    tilt_result_t r;
    longint a, roll, smooth, rate, hp;
    a = longint'(mdl_coeff);
    r.pitch = 16'(vector_angle(ay, floor_sqrt(longint'(ax * ax + az * az))));
    roll = vector_angle(-ax, floor_sqrt(longint'(ay * ay + az * az)));
    roll = clamp16(roll - longint'(mdl_offset));
    smooth = clamp16(((65536 - a) * longint'(mdl_last_roll) + a * longint'(mdl_lowpass)
                      + 32768) >>> 16);
    rate = clamp16((gy * 572224 + 524288) >>> 20);
    hp = clamp16((a * longint'(mdl_highpass) + (rate - longint'(mdl_last_rate)) * 65536
                  + 32768) >>> 16);
    mdl_last_roll = 16'(roll);
    mdl_lowpass = 16'(smooth);
    mdl_last_rate = 16'(rate);
    mdl_highpass = 16'(hp);
    r.roll = 16'(roll);
    r.smooth = 16'(smooth);
    r.rate = 16'(rate);
    r.rate_hp = 16'(hp);
    return r;
  endfunction

  // bursty sender: gaps of random length fall between bursts
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, logic signed [15:0] gy);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    accel_x = ax;
    accel_y = ay;
    accel_z = az;
    gyro_y = gy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_tilt_q.push_back(predict_tilt(ax, ay, az, gy));
    samples_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (expected_tilt_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [itf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == itf_pkg::REG_FILTER_COEFF) mdl_coeff = value;
    else if (idx == itf_pkg::REG_ROLL_OFFSET) mdl_offset = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random(int count);
    logic signed [15:0] gx, gy2, gz, base;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0: send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        1: begin
          // gravity-like vector near rest with small tilt and rate
          gx = 16'($urandom_range(0, 4000) - 2000);
          gy2 = 16'($urandom_range(0, 4000) - 2000);
          gz = 16'(16384 + $urandom_range(0, 2000) - 1000);
          send_sample(gx, gy2, ($urandom_range(0, 7) == 0) ? -gz : gz,
                      16'($urandom_range(0, 2000) - 1000));
        end
        2: begin
          // slow drift so the filters see correlated history
          base = 16'($urandom_range(0, 20000) - 10000);
          for (int k = 0; k < 6 && n < count; k++, n++)
            send_sample(16'(base + 300 * k), -base, 16'(12000), 16'(base + 100 * k));
          n--;
        end
        default: send_sample(16'($urandom_range(0, 60) - 30), 16'($urandom_range(0, 60) - 30),
                             16'($urandom_range(0, 60) - 30), 16'($urandom));
      endcase
    end
  endtask

  task automatic test_special_cases;
    send_sample(0, 0, 0, 0);
    send_sample(0, 1000, 0, 131);
    send_sample(0, -1000, 0, -131);
    send_sample(-32768, 0, 0, 0);
    send_sample(32767, 0, 0, 32767);
    send_sample(-32768, -32768, -32768, -32768);
    send_sample(32767, 32767, 32767, 32767);
    send_sample(-32768, 32767, -32768, 0);
    send_sample(0, 0, 16384, 1);
    send_sample(0, 0, -16384, -1);
    send_sample(16384, 0, 0, 5000);
    send_sample(-1, -1, -1, -32768);
    send_sample(1, 1, 1, 32767);
    send_sample(0, 0, 0, 0);
  endtask

  task automatic test_register_sweep;
    drain();
    write_reg(itf_pkg::REG_FILTER_COEFF, 16'd0);
    write_reg(itf_pkg::REG_ROLL_OFFSET, 16'h8000);
    send_random(40);
    drain();
    write_reg(itf_pkg::REG_FILTER_COEFF, 16'hFFFF);
    write_reg(itf_pkg::REG_ROLL_OFFSET, 16'h7FFF);
    send_random(40);
    drain();
    // writes to unused indexes must change nothing
    write_reg(REG_UNUSED_A, 16'h1234);
    write_reg(REG_UNUSED_B, 16'hFFFF);
    send_random(20);
    drain();
    write_reg(itf_pkg::REG_FILTER_COEFF, 16'd1);
    write_reg(itf_pkg::REG_ROLL_OFFSET, 16'h0000);
    send_random(30);
    for (int p = 0; p < 4; p++) begin
      drain();
      write_reg(itf_pkg::REG_FILTER_COEFF, 16'($urandom));
      write_reg(itf_pkg::REG_ROLL_OFFSET, 16'($urandom));
      send_random(40);
    end
  endtask

  task automatic test_random_stream;
    drain();
    write_reg(itf_pkg::REG_FILTER_COEFF, itf_pkg::COEFF_RESET);
    write_reg(itf_pkg::REG_ROLL_OFFSET, 16'($urandom_range(0, 1000) - 500));
    send_random(1000);
  endtask

  // receiver stall pattern: phases of none, light and heavy stalling
  initial begin
    int mode, span;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(50, 400);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 9) < 3);
          default: out_stall = ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic check_field(string name, logic signed [15:0] exp_v,
                             logic signed [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    tilt_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_tilt_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $realtime);
        errors++;
      end else begin
        exp_r = expected_tilt_q.pop_front();
        check_field("pitch_angle", exp_r.pitch, pitch_angle);
        check_field("roll_angle", exp_r.roll, roll_angle);
        check_field("roll_smoothed", exp_r.smooth, roll_smoothed);
        check_field("body_rate", exp_r.rate, body_rate);
        check_field("rate_highpassed", exp_r.rate_hp, rate_highpassed);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("imu_tilt_filter regression: fail");
      $finish;
    end
  end

  initial begin
    mdl_coeff = itf_pkg::COEFF_RESET;
    mdl_offset = '0;
    mdl_last_roll = '0;
    mdl_lowpass = '0;
    mdl_last_rate = '0;
    mdl_highpass = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_special_cases();
    test_register_sweep();
    test_random_stream();
    drain();
    if (expected_tilt_q.size() != 0) errors++;
    $display("covered %0d samples, %0d results, %0d register writes, %0d errors",
             samples_sent, results_seen, cfg_writes, errors);
    if (errors == 0) begin
      $display("imu_tilt_filter regression: pass");
    end else begin
      $display("imu_tilt_filter regression: fail");
    end
    $finish;
  end

endmodule
